>>> rtl/core/lco_pkg.sv
// ----------------------------------------------------------------------------
// lco_pkg
// Shared constants, types and the darkness threshold for the line centroid
// offset block.
// ----------------------------------------------------------------------------
package lco_pkg;

    localparam int MAX_ROW_PIXELS_DEF = 1024;

    // darkness thresholds on d = 255 - gray
    localparam int         DARK_MAX_INT = 255;
    localparam logic [7:0] DARK_MAX     = 8'd255;
    localparam logic [7:0] DARK_LOW     = 8'd85;
    localparam logic [7:0] DARK_HIGH    = 8'd171;

    // Q15 result format
    localparam int          Q15_FRAC_BITS = 15;
    localparam int          Q_BITS        = 16;
    localparam int          Q_CNT_W       = $clog2(Q_BITS);
    localparam logic [15:0] Q15_MAX       = 16'h7FFF;
    localparam logic [15:0] Q15_HALF      = 16'h4000;

    // finished-row queue between accumulator and divider
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic full;
        logic empty;
    } lco_q_status_t;

    typedef enum logic [3:0] {
        BK_IDLE = 4'b0001,
        BK_MUL  = 4'b0010,
        BK_DIV  = 4'b0100,
        BK_OUT  = 4'b1000
    } lco_back_state_t;

    function automatic logic [7:0] dark_level(input logic [7:0] gray);
        logic [7:0] d;
        d = DARK_MAX - gray;
        if (d <= DARK_LOW)
            return 8'd0;
        if (d >= DARK_HIGH)
            return DARK_MAX;
        return d;
    endfunction

endpackage

>>> rtl/core/lco_if.sv
// ----------------------------------------------------------------------------
// lco_if
// Valid/ready channels for pixel words and result words.
// ----------------------------------------------------------------------------
interface lco_pixel_if;
    logic       valid;
    logic       ready;
    logic [7:0] gray_level;
    logic       row_end;

    modport source (output valid, output gray_level, output row_end, input ready);
    modport sink   (input valid, input gray_level, input row_end, output ready);
endinterface

interface lco_result_if;
    logic               valid;
    logic               ready;
    logic               line_found;
    logic signed [15:0] line_offset;

    modport source (output valid, output line_found, output line_offset, input ready);
    modport sink   (input valid, input line_found, input line_offset, output ready);
endinterface

>>> rtl/core/line_centroid_offset.sv
// ----------------------------------------------------------------------------
// line_centroid_offset
// Darkness-weighted centroid of one camera row, as a signed Q15 offset from
// the row center.
// ----------------------------------------------------------------------------
// Pixels are taken one word per clock while the queue is not full. Each row's
// sums go into a two-entry queue on the row_end word. A divider behind it
// presents the result after queue pop, the multiply, 16 restoring-divide steps
// and the output load. It takes a new row only once it has loaded the result
// of the last one. Pixel input stalls only while both queue entries hold rows
// still waiting for the divider. That can happen only with rows shorter than
// 19 pixels or a stalled result channel. Pixels beyond MAX_ROW_PIXELS in a row
// are ignored, but a row_end on them still closes the row.
module line_centroid_offset #(
    parameter int MAX_ROW_PIXELS = lco_pkg::MAX_ROW_PIXELS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    lco_pixel_if.sink     pixel,
    lco_result_if.source  result
);

    localparam int IW = $clog2(MAX_ROW_PIXELS + 1);
    localparam int WW = $clog2(lco_pkg::DARK_MAX_INT * MAX_ROW_PIXELS + 1);
    localparam longint unsigned MOMENT_MAX =
        64'(lco_pkg::DARK_MAX_INT) * 64'(MAX_ROW_PIXELS) * 64'(MAX_ROW_PIXELS - 1) / 64'd2;
    localparam int MW = $clog2(MOMENT_MAX + 64'd1);
    localparam int EW = IW + WW + MW;

    lco_pkg::lco_q_status_t q_status;
    logic                   q_push;
    logic                   q_pop;
    logic [EW-1:0]          q_in;
    logic [EW-1:0]          q_head;

    lco_front #(
        .MAX_ROW_PIXELS (MAX_ROW_PIXELS),
        .IW             (IW),
        .WW             (WW),
        .MW             (MW)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .pixel    (pixel),
        .q_status (q_status),
        .q_push   (q_push),
        .q_data   (q_in)
    );

    lco_queue #(
        .DATA_W (EW),
        .DEPTH  (lco_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .head_data (q_head),
        .status    (q_status)
    );

    lco_back #(
        .IW (IW),
        .WW (WW),
        .MW (MW)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_status (q_status),
        .q_data   (q_head),
        .q_pop    (q_pop),
        .result   (result)
    );

`ifndef SYNTHESIS
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_status.full)
        else $error("row pushed into full queue");

    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_status.empty)
        else $error("pop from empty queue");

    a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.line_found) |-> (result.line_offset == 16'sd0))
        else $error("offset nonzero with no line");

    a_offset_range: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.line_found) |->
            ((result.line_offset >= -16'sd16384) && (result.line_offset <= 16'sd16383)))
        else $error("offset out of Q15 half range");
`endif

endmodule

>>> rtl/core/lco_queue.sv
// ----------------------------------------------------------------------------
// lco_queue
// Small show-ahead FIFO holding finished row sums for the divider.
// ----------------------------------------------------------------------------
module lco_queue #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = lco_pkg::QUEUE_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  logic [DATA_W-1:0]     push_data,
    input  logic                  pop,
    output logic [DATA_W-1:0]     head_data,
    output lco_pkg::lco_q_status_t status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(DEPTH - 1))
            return '0;
        return p + PTR_W'(1);
    endfunction

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop  ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

    assign head_data    = mem[rd_ptr_reg];
    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);

endmodule

>>> rtl/core/lco_front.sv
// ----------------------------------------------------------------------------
// lco_front
// Per-pixel darkness threshold and row accumulation; pushes the row sums
// into the queue on the last pixel.
// ----------------------------------------------------------------------------
module lco_front #(
    parameter int MAX_ROW_PIXELS = lco_pkg::MAX_ROW_PIXELS_DEF,
    parameter int IW = $clog2(MAX_ROW_PIXELS + 1),
    parameter int WW = $clog2(lco_pkg::DARK_MAX_INT * MAX_ROW_PIXELS + 1),
    parameter int MW = 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    lco_pixel_if.sink              pixel,
    input  lco_pkg::lco_q_status_t q_status,
    output logic                   q_push,
    output logic [IW+WW+MW-1:0]    q_data
);

    localparam int PW = 8 + IW;

    logic [IW-1:0] index_reg, index_next;
    logic [WW-1:0] weight_reg, weight_next;
    logic [MW-1:0] moment_reg, moment_next;

    logic          accept;
    logic          in_row;
    logic [7:0]    dark;
    logic [PW-1:0] prod;
    logic [IW-1:0] index_acc;
    logic [WW-1:0] weight_acc;
    logic [MW-1:0] moment_acc;

    assign pixel.ready = !q_status.full;
    assign accept      = pixel.valid && pixel.ready;

    // pixels past the row limit do not count
    assign in_row = (index_reg < IW'(MAX_ROW_PIXELS));
    assign dark   = lco_pkg::dark_level(pixel.gray_level);
    assign prod   = PW'(dark) * PW'(index_reg);

    always_comb
    begin
        index_acc  = index_reg;
        weight_acc = weight_reg;
        moment_acc = moment_reg;
        if (in_row)
        begin
            index_acc  = index_reg + IW'(1);
            weight_acc = weight_reg + WW'(dark);
            moment_acc = moment_reg + MW'(prod);
        end

        index_next  = index_reg;
        weight_next = weight_reg;
        moment_next = moment_reg;
        if (accept)
        begin
            if (pixel.row_end)
            begin
                index_next  = '0;
                weight_next = '0;
                moment_next = '0;
            end
            else
            begin
                index_next  = index_acc;
                weight_next = weight_acc;
                moment_next = moment_acc;
            end
        end
    end

    assign q_push = accept && pixel.row_end;
    assign q_data = {index_acc, weight_acc, moment_acc};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            index_reg  <= '0;
            weight_reg <= '0;
            moment_reg <= '0;
        end
        else
        begin
            index_reg  <= index_next;
            weight_reg <= weight_next;
            moment_reg <= moment_next;
        end
    end

endmodule

>>> rtl/core/lco_back.sv
// ----------------------------------------------------------------------------
// lco_back
// Per-row offset: denominator multiply, 16-step restoring divide of
// moment * 2^15 by weight * width (skipped for zero weight or moment), Q15 centering, output register.
// ----------------------------------------------------------------------------
module lco_back #(
    parameter int IW = 11,
    parameter int WW = 18,
    parameter int MW = 28
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  lco_pkg::lco_q_status_t q_status,
    input  logic [IW+WW+MW-1:0]    q_data,
    output logic                   q_pop,
    lco_result_if.source           result
);

    localparam int DW    = WW + IW;
    localparam int QB    = lco_pkg::Q_BITS;
    localparam int CNT_W = lco_pkg::Q_CNT_W;
    localparam int FB    = lco_pkg::Q15_FRAC_BITS;

    lco_pkg::lco_back_state_t state_reg, state_next;

    logic [IW-1:0]    width_reg, width_next;
    logic [WW-1:0]    weight_reg, weight_next;
    logic [MW-1:0]    moment_reg, moment_next;
    logic [DW-1:0]    denom_reg, denom_next;
    logic [DW-1:0]    rem_reg, rem_next;
    logic [QB-1:0]    numer_reg, numer_next;
    logic [QB-1:0]    quot_reg, quot_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             found_reg, found_next;

    logic             out_valid_reg, out_valid_next;
    logic             out_found_reg, out_found_next;
    logic [15:0]      out_offset_reg, out_offset_next;

    logic [DW:0]      trial;
    logic             ge;
    logic [15:0]      q_clamped;

    assign trial     = {rem_reg, numer_reg[QB-1]};
    assign ge        = (trial >= {1'b0, denom_reg});
    assign q_clamped = (quot_reg > lco_pkg::Q15_MAX) ? lco_pkg::Q15_MAX : quot_reg;

    always_comb
    begin
        state_next      = state_reg;
        width_next      = width_reg;
        weight_next     = weight_reg;
        moment_next     = moment_reg;
        denom_next      = denom_reg;
        rem_next        = rem_reg;
        numer_next      = numer_reg;
        quot_next       = quot_reg;
        cnt_next        = cnt_reg;
        found_next      = found_reg;
        out_found_next  = out_found_reg;
        out_offset_next = out_offset_reg;
        out_valid_next  = out_valid_reg && !result.ready;
        q_pop           = 1'b0;

        case (state_reg)
            lco_pkg::BK_IDLE:
            begin
                if (!q_status.empty)
                begin
                    q_pop = 1'b1;
                    {width_next, weight_next, moment_next} = q_data;
                    state_next = lco_pkg::BK_MUL;
                end
            end
            lco_pkg::BK_MUL:
            begin
                denom_next = DW'(weight_reg) * DW'(width_reg);
                // moment < weight * width, so moment >> 1 fits below the divisor
                rem_next   = DW'(moment_reg >> 1);
                numer_next = {moment_reg[0], {FB{1'b0}}};
                quot_next  = '0;
                cnt_next   = '0;
                found_next = (weight_reg != '0) && (moment_reg != '0);
                if ((weight_reg != '0) && (moment_reg != '0))
                    state_next = lco_pkg::BK_DIV;
                else
                    state_next = lco_pkg::BK_OUT;
            end
            lco_pkg::BK_DIV:
            begin
                if (ge)
                    rem_next = DW'(trial - {1'b0, denom_reg});
                else
                    rem_next = trial[DW-1:0];
                quot_next  = {quot_reg[QB-2:0], ge};
                numer_next = {numer_reg[QB-2:0], 1'b0};
                cnt_next   = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(QB - 1))
                    state_next = lco_pkg::BK_OUT;
            end
            lco_pkg::BK_OUT:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_found_next  = found_reg;
                    out_offset_next = found_reg ? (q_clamped - lco_pkg::Q15_HALF) : 16'd0;
                    state_next      = lco_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = lco_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lco_pkg::BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        width_reg      <= width_next;
        weight_reg     <= weight_next;
        moment_reg     <= moment_next;
        denom_reg      <= denom_next;
        rem_reg        <= rem_next;
        numer_reg      <= numer_next;
        quot_reg       <= quot_next;
        cnt_reg        <= cnt_next;
        found_reg      <= found_next;
        out_found_reg  <= out_found_next;
        out_offset_reg <= out_offset_next;
    end

    assign result.valid       = out_valid_reg;
    assign result.line_found  = out_found_reg;
    assign result.line_offset = $signed(out_offset_reg);

endmodule
